[sv/smp_pkg.sv]
// Shared types, codes and sizes for the SPI slave memory port.
`default_nettype none
package smp_pkg;

    // Byte store size (a power of two) and the address width it needs
    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MEM_BYTES);

    // Depth of the queue between the decoder and the executor
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [7:0] REG_WR_DATA_OPC  = 8'd0;
    localparam logic [7:0] REG_RD_DATA_OPC  = 8'd1;
    localparam logic [7:0] REG_RD_STAT_OPC  = 8'd2;
    localparam logic [7:0] REG_WR_CTRL_OPC  = 8'd3;

    // Opcode reset values
    localparam logic [7:0] RST_WR_DATA_OPC = 8'd2;
    localparam logic [7:0] RST_RD_DATA_OPC = 8'd3;
    localparam logic [7:0] RST_RD_STAT_OPC = 8'd5;
    localparam logic [7:0] RST_WR_CTRL_OPC = 8'd1;

    // Position within a frame
    localparam logic [1:0] POS_IDLE = 2'd0;
    localparam logic [1:0] POS_CMD  = 2'd1;
    localparam logic [1:0] POS_ADDR = 2'd2;
    localparam logic [1:0] POS_DATA = 2'd3;

    // Work handed from the decoder to the executor
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_MEM_WR = 2'd1;
    localparam logic [1:0] OP_MEM_RD = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    typedef logic [1:0] smp_op_t;

    typedef struct packed {
        smp_op_t           op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [7:0]        ctl;
        logic              bad;
    } smp_entry_t;

endpackage
`default_nettype wire

[sv/spi_slave_memory_port.sv]
// SPI slave memory port, top level.
//
// Each transfer on the s_ side is one byte slot of the serial bus; s_tuser
// flags the first byte after chip select falls. The first byte of a frame is
// the command; data commands take two address bytes, then each byte is
// written to or read from a 4096-byte store with a wrapping address.
// Every slot gives exactly one transfer on the m_ side with the returned
// byte, the control register and the unknown-command flag.
// Opcodes are set through the cfg_ channel (index 0 write data, 1 read data,
// 2 read status, 3 write control); cfg_ready is always high, and writes
// belong between frames while no slot is in flight.
// A slot reaches m_tvalid via the queue, the executor's held operation and
// the output register. One slot per cycle is sustained with m_tready high:
// the decoder, two-entry queue and single-port store take one operation a cycle.
// A stall on m_tready fills the output register, the executor's held
// operation and then the queue, so four slots are absorbed before s_tready
// drops; nothing is lost. Reset clears frame state, control and opcodes to
// defaults; the store is left as it is, unwritten bytes read back as
// undefined.
`default_nettype none
module spi_slave_memory_port (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] in_byte, [15:8] status_value
    input  wire logic [0:0]  s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [15:8] control_value
    output logic [0:0]       m_tuser    // [0] bad_command
);
    import smp_pkg::*;

    logic       push_valid, push_ready, pop_valid, pop_ready;
    smp_entry_t push_entry, pop_entry;

    smp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .frame_start  (s_tuser[0]),
        .in_byte      (s_tdata[7:0]),
        .status_value (s_tdata[15:8]),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    smp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    smp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
`default_nettype wire

[sv/smp_front.sv]
// Decoder: configuration registers, frame tracking and command classification.
`default_nettype none
module smp_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_index,
    input  wire logic [7:0]          cfg_data,
    // byte slot transfer
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                frame_start,
    input  wire logic [7:0]          in_byte,
    input  wire logic [7:0]          status_value,
    // push side of the queue
    output logic                     push_valid,
    input  wire logic                push_ready,
    output smp_pkg::smp_entry_t      push_entry
);
    import smp_pkg::*;

    logic [7:0]  wr_opc_reg, rd_opc_reg, st_opc_reg, ctl_opc_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  ctl_reg, ctl_next;
    logic        is_wr, is_rd, is_st, is_ctl;
    logic        accept;
    logic [ADDR_W-1:0] addr_inc;

    assign cfg_ready  = 1'b1;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;
    assign addr_inc   = addr_reg[ADDR_W-1:0] + 1'b1;

    // Classify the frame's command in priority order
    always_comb
    begin
        is_wr  = (cmd_reg == wr_opc_reg);
        is_rd  = !is_wr && (cmd_reg == rd_opc_reg);
        is_st  = !is_wr && !is_rd && (cmd_reg == st_opc_reg);
        is_ctl = !is_wr && !is_rd && !is_st && (cmd_reg == ctl_opc_reg);
    end

    // Work out the next frame state and the operation for this slot
    always_comb
    begin
        pos_next        = pos_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        ctl_next        = ctl_reg;
        push_entry.op   = OP_NONE;
        push_entry.addr = addr_reg[ADDR_W-1:0];
        push_entry.data = in_byte;
        if (frame_start)
        begin
            cmd_next = in_byte;
            pos_next = POS_CMD;
        end
        else if (pos_reg != POS_IDLE)
        begin
            if (is_wr || is_rd)
            begin
                unique case (pos_reg)
                    POS_CMD:
                    begin
                        addr_next = {in_byte, 8'h00};
                        pos_next  = POS_ADDR;
                    end
                    POS_ADDR:
                    begin
                        addr_next = 16'({addr_reg[15:8], addr_reg[7:0] | in_byte}
                                        & 16'(MEM_BYTES - 1));
                        pos_next  = POS_DATA;
                    end
                    default:
                    begin
                        push_entry.op = is_wr ? OP_MEM_WR : OP_MEM_RD;
                        addr_next     = 16'(addr_inc);
                    end
                endcase
            end
            else if (is_st)
            begin
                push_entry.op   = OP_STATUS;
                push_entry.data = status_value;
            end
            else if (is_ctl && (pos_reg == POS_CMD))
            begin
                ctl_next = in_byte;
                pos_next = POS_ADDR;
            end
        end
        push_entry.ctl = ctl_next;
        push_entry.bad = (pos_next != POS_IDLE) &&
                         (cmd_next != wr_opc_reg) && (cmd_next != rd_opc_reg) &&
                         (cmd_next != st_opc_reg) && (cmd_next != ctl_opc_reg);
    end

    // Hold frame state, advance on each accepted slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_IDLE;
            cmd_reg  <= 8'h00;
            addr_reg <= 16'h0000;
            ctl_reg  <= 8'h00;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            cmd_reg  <= cmd_next;
            addr_reg <= addr_next;
            ctl_reg  <= ctl_next;
        end
    end

    // Load opcode registers on a configuration transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_opc_reg  <= RST_WR_DATA_OPC;
            rd_opc_reg  <= RST_RD_DATA_OPC;
            st_opc_reg  <= RST_RD_STAT_OPC;
            ctl_opc_reg <= RST_WR_CTRL_OPC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WR_DATA_OPC: wr_opc_reg  <= cfg_data;
                REG_RD_DATA_OPC: rd_opc_reg  <= cfg_data;
                REG_RD_STAT_OPC: st_opc_reg  <= cfg_data;
                REG_WR_CTRL_OPC: ctl_opc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/smp_queue.sv]
// Short queue of decoded operations between the decoder and the executor.
`default_nettype none
module smp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire smp_pkg::smp_entry_t push_entry,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output smp_pkg::smp_entry_t      pop_entry
);
    import smp_pkg::*;

    smp_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

[sv/smp_back.sv]
// Executor: byte store access and the registered result stage.
`default_nettype none
module smp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire smp_pkg::smp_entry_t pop_entry,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [15:0]              out_data,
    output logic [0:0]               out_user
);
    import smp_pkg::*;

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rd_data_reg;
    logic       pend_valid_reg;
    smp_op_t    pend_op_reg;
    logic [7:0] pend_data_reg, pend_ctl_reg;
    logic       pend_bad_reg;
    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic [0:0] out_user_reg;
    logic       pend_move, do_pop;
    logic [7:0] result;

    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign pop_ready = !pend_valid_reg || pend_move;
    assign do_pop    = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    // Access the byte store when an operation is taken
    always_ff @(posedge clk)
    begin
        if (do_pop && (pop_entry.op == OP_MEM_WR))
            mem[pop_entry.addr] <= pop_entry.data;
        if (do_pop && (pop_entry.op == OP_MEM_RD))
            rd_data_reg <= mem[pop_entry.addr];
    end

    // Hold the operation while its read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (pop_ready)
            pend_valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            pend_op_reg   <= pop_entry.op;
            pend_data_reg <= pop_entry.data;
            pend_ctl_reg  <= pop_entry.ctl;
            pend_bad_reg  <= pop_entry.bad;
        end
    end

    // Select the returned byte
    always_comb
    begin
        unique case (pend_op_reg)
            OP_MEM_RD: result = rd_data_reg;
            OP_STATUS: result = pend_data_reg;
            default:   result = 8'h00;
        endcase
    end

    // Output register: load when empty or being taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= pend_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            out_data_reg <= {pend_ctl_reg, result};
            out_user_reg <= pend_bad_reg;
        end
    end

endmodule
`default_nettype wire
